### hdl/sphc_pkg.sv
// sphc_pkg: shared widths, constants and register codes for the screen point
// to hex cell block; no dependencies
package sphc_pkg;

	// field widths
	localparam int SCR_W  = 12;
	localparam int VP_W   = 13;
	localparam int PAN_W  = 24;
	localparam int ZOOM_W = 20;
	localparam int OUT_W  = 16;

	// moved point in 1/256 pixel: signed width and magnitude width
	localparam int M_W   = 25;
	localparam int MAG_W = 24;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// world coordinates are clamped to +-2^WORLD_LIMIT_BITS units
	localparam int WORLD_LIMIT_BITS = 17;

	// hex scale factors in Q20, magnitudes (the y factor is negative)
	localparam int K_W     = 21;
	localparam int K_SHIFT = 20;
	localparam logic [K_W-1:0] K_HX_MAG = 21'd1210791;
	localparam logic [K_W-1:0] K_HY_MAG = 21'd699051;

	// low slice of the world magnitude in the split multiply
	localparam int PP_LO_W = 17;

	// register reset values
	localparam logic [VP_W-1:0]   VW_RST   = 13'd1024;
	localparam logic [VP_W-1:0]   VH_RST   = 13'd768;
	localparam logic [ZOOM_W-1:0] ZOOM_RST = 20'd8192;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VIEWPORT_WIDTH  = 3'd0,
		CFG_VIEWPORT_HEIGHT = 3'd1,
		CFG_PAN_X           = 3'd2,
		CFG_PAN_Y           = 3'd3,
		CFG_ZOOM            = 3'd4
	} cfg_idx_t;

endpackage

### hdl/sphc_div.sv
// sphc_div: two-lane pipelined restoring divider, one quotient bit per stage,
// rounded magnitudes in, clamped signed world coordinates out; uses sphc_pkg
module sphc_div #(
	parameter int FRAC_BITS = 16,
	localparam int NW = sphc_pkg::MAG_W + FRAC_BITS + 2,
	localparam int WW = FRAC_BITS + sphc_pkg::WORLD_LIMIT_BITS + 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic                        in_neg [2],
	input  logic [NW-1:0]               in_num [2],
	input  logic [sphc_pkg::ZOOM_W-1:0] zdiv,
	output logic                        out_vld,
	output logic signed [WW-1:0]        out_w [2]
);
	import sphc_pkg::*;

	// quotient bits kept, magnitude width and clamp value
	localparam int QB = FRAC_BITS + WORLD_LIMIT_BITS + 1;
	localparam int AW = WW - 1;
	localparam logic [AW-1:0] LIM = {1'b1, {(AW-1){1'b0}}};

	// stage registers, index 0 is the entry stage
	logic                vld_s [0:QB];
	logic                neg_s [0:QB][0:1];
	logic                ovf_s [0:QB][0:1];
	logic [ZOOM_W-1:0]   rem_s [0:QB][0:1];
	logic [QB-1:0]       quo_s [0:QB][0:1];
	logic [QB-1:0]       low_s [0:QB][0:1];

	logic [ZOOM_W-1:0]   rem_n [0:QB-1][0:1];
	logic                qbit_n [0:QB-1][0:1];
	logic [ZOOM_W-1:0]   hi_c [0:1];
	logic                ovf_c [0:1];
	logic [AW-1:0]       mag_c [0:1];

	logic                vld_so;
	logic signed [WW-1:0] w_so [0:1];

	// entry: quotients of 2^QB or more are clamped anyway
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			hi_c[l]  = ZOOM_W'(in_num[l][NW-1:QB]);
			ovf_c[l] = (hi_c[l] >= zdiv);
		end
	end

	// one shift, compare and subtract per stage
	always_comb begin
		logic [ZOOM_W:0] t;
		t = '0;
		for (int k = 0; k < QB; k++) begin
			for (int l = 0; l < 2; l++) begin
				t = {rem_s[k][l], low_s[k][l][QB-1]};
				if (t >= {1'b0, zdiv}) begin
					rem_n[k][l]  = ZOOM_W'(t - {1'b0, zdiv});
					qbit_n[k][l] = 1'b1;
				end else begin
					rem_n[k][l]  = t[ZOOM_W-1:0];
					qbit_n[k][l] = 1'b0;
				end
			end
		end
	end

	// clamp to the world limit
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (ovf_s[QB][l] || (quo_s[QB][l] > LIM)) begin
				mag_c[l] = LIM;
			end else begin
				mag_c[l] = quo_s[QB][l];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) begin
				vld_s[k] <= 1'b0;
			end
			vld_so <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			for (int k = 0; k < QB; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			vld_so <= vld_s[QB];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			neg_s[0][l] <= in_neg[l];
			ovf_s[0][l] <= ovf_c[l];
			rem_s[0][l] <= ovf_c[l] ? '0 : hi_c[l];
			quo_s[0][l] <= '0;
			low_s[0][l] <= in_num[l][QB-1:0];
			for (int k = 0; k < QB; k++) begin
				neg_s[k+1][l] <= neg_s[k][l];
				ovf_s[k+1][l] <= ovf_s[k][l];
				rem_s[k+1][l] <= rem_n[k][l];
				quo_s[k+1][l] <= {quo_s[k][l][QB-2:0], qbit_n[k][l]};
				low_s[k+1][l] <= {low_s[k][l][QB-2:0], 1'b0};
			end
			w_so[l] <= neg_s[QB][l] ? -signed'({1'b0, mag_c[l]}) : signed'({1'b0, mag_c[l]});
		end
	end

	assign out_vld  = vld_so;
	assign out_w[0] = w_so[0];
	assign out_w[1] = w_so[1];

endmodule

### hdl/screen_point_to_hex_cell.sv
// screen_point_to_hex_cell: top level, maps a screen pixel to a hex cell
// depends on sphc_pkg and sphc_div
//
// Usage:
//   Input items: drive screen_x, screen_y and pulse start; an item is taken
//   on every clock edge with start high and busy low. busy stays low, so one
//   item can enter in every cycle.
//   Results: cell_column (2q+r) and cell_row (r) show for one cycle with done
//   high, in the order items came in. The receiver cannot stall the block.
//   Pipeline: the restoring divider for the zoom resolves one quotient bit
//   per stage over FRAC_BITS + 18 stages. Throughput: one item per cycle.
//   Configuration: wr_en with wr_index and wr_data writes one register at
//   the clock edge; unknown indexes are dropped. Write only while no item is
//   in flight.
//   Reset: arst_n clears all valid bits and loads the register defaults
//   (1024 x 768 viewport, no pan, zoom 8192); items in flight are dropped.
module screen_point_to_hex_cell #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [sphc_pkg::SCR_W-1:0]       screen_x,
	input  logic [sphc_pkg::SCR_W-1:0]       screen_y,
	output logic                             done,
	output logic signed [sphc_pkg::OUT_W-1:0] cell_column,
	output logic signed [sphc_pkg::OUT_W-1:0] cell_row,
	input  logic                             wr_en,
	input  logic [sphc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [sphc_pkg::CFG_DATA_W-1:0]  wr_data
);
	import sphc_pkg::*;

	// derived widths
	localparam int NW  = MAG_W + FRAC_BITS + 2;
	localparam int WW  = FRAC_BITS + WORLD_LIMIT_BITS + 2;
	localparam int AW  = WW - 1;
	localparam int PW  = AW + K_W;
	localparam int PLW = PP_LO_W + K_W;
	localparam int PHW = AW - PP_LO_W + K_W;
	localparam int HSW = AW + 1;
	localparam int CW  = AW + 3;
	localparam int IMW = CW - FRAC_BITS - 1;
	localparam int IW  = IMW + 1;
	localparam int XW  = IW + 1;
	localparam int YW  = XW + 2;

	localparam logic [PW-1:0] RND_H  = PW'(1) << (K_SHIFT - 1);
	localparam logic [CW-1:0] HALF_C = CW'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS+1:0] ONE_C = (FRAC_BITS+2)'(1) << (FRAC_BITS + 1);
	localparam logic signed [YW-1:0] SMAX = signed'(YW'((1 << (OUT_W - 1)) - 1));
	localparam logic signed [YW-1:0] SMIN = -SMAX - YW'(1);

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [YW-1:0] v);
		logic signed [YW-1:0] c;
		c = v;
		if (v > SMAX) begin
			c = SMAX;
		end else if (v < SMIN) begin
			c = SMIN;
		end
		return c[OUT_W-1:0];
	endfunction

	// configuration registers
	logic [VP_W-1:0]          vw_q;
	logic [VP_W-1:0]          vh_q;
	logic signed [PAN_W-1:0]  pan_x_q;
	logic signed [PAN_W-1:0]  pan_y_q;
	logic [ZOOM_W-1:0]        zoom_q;
	logic [ZOOM_W-1:0]        zeff;

	// pipeline registers
	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic                     vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [M_W-1:0]    mx_s1, my_s1;
	logic [NW-1:0]            num_s2 [2];
	logic                     neg_s2 [2];
	logic [PP_LO_W+K_W-1:0]   plo_s3 [2];
	logic [AW-PP_LO_W+K_W-1:0] phi_s3 [2];
	logic                     hneg_s3 [2];
	logic signed [HSW-1:0]    h_s4 [2];
	logic signed [CW-1:0]     c_s5 [3];
	logic signed [IW-1:0]     i_s6 [3];
	logic [FRAC_BITS:0]       d_s6 [3];
	logic signed [XW-1:0]     qf_s7, rf_s7;
	logic signed [OUT_W-1:0]  col_s8, row_s8;

	// combinational signals
	logic signed [M_W:0]      sx_e, sy_e, vw_e, vh_e, px_e, py_e, mx_c, my_c;
	logic [M_W-1:0]           ax_c, ay_c;
	logic                     vld_d;
	logic signed [WW-1:0]     w_d [2];
	logic [AW-1:0]            wa_c [2];
	logic [PW-1:0]            p_c [2];
	logic [AW-1:0]            hm_c [2];
	logic signed [CW-1:0]     hx_e, hy_e;
	logic [CW-1:0]            ca_c [3];
	logic [CW-1:0]            cs_c [3];
	logic [IMW-1:0]           im_c [3];
	logic [FRAC_BITS+1:0]     dd_c [3];
	logic                     q_big, r_big;
	logic signed [YW-1:0]     col_c;

	// busy never rises, so every cycle can take an item
	assign busy = 1'b0;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q    <= VW_RST;
			vh_q    <= VH_RST;
			pan_x_q <= '0;
			pan_y_q <= '0;
			zoom_q  <= ZOOM_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_VIEWPORT_WIDTH: begin
					vw_q <= wr_data[VP_W-1:0];
				end
				CFG_VIEWPORT_HEIGHT: begin
					vh_q <= wr_data[VP_W-1:0];
				end
				CFG_PAN_X: begin
					pan_x_q <= signed'(wr_data[PAN_W-1:0]);
				end
				CFG_PAN_Y: begin
					pan_y_q <= signed'(wr_data[PAN_W-1:0]);
				end
				CFG_ZOOM: begin
					zoom_q <= wr_data[ZOOM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// zero zoom divides as one
	assign zeff = (zoom_q == '0) ? ZOOM_W'(1) : zoom_q;

	// s1: center, pan and flip y, exact in 1/256 pixel
	always_comb begin
		sx_e = signed'((M_W+1)'({screen_x, 8'd0}));
		sy_e = signed'((M_W+1)'({screen_y, 8'd0}));
		vw_e = signed'((M_W+1)'({vw_q, 7'd0}));
		vh_e = signed'((M_W+1)'({vh_q, 7'd0}));
		px_e = (M_W+1)'(pan_x_q);
		py_e = (M_W+1)'(pan_y_q);
		mx_c = sx_e - vw_e + px_e;
		my_c = vh_e - sy_e - py_e;
	end

	// s2: magnitude, scale up and add half the divisor
	always_comb begin
		ax_c = mx_s1[M_W-1] ? M_W'(-mx_s1) : M_W'(mx_s1);
		ay_c = my_s1[M_W-1] ? M_W'(-my_s1) : M_W'(my_s1);
	end

	sphc_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s2),
		.in_neg  (neg_s2),
		.in_num  (num_s2),
		.zdiv    (zeff),
		.out_vld (vld_d),
		.out_w   (w_d)
	);

	// s3 and s4: hex scaling as a split multiply, then round
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			wa_c[l] = w_d[l][WW-1] ? AW'(-w_d[l]) : AW'(w_d[l]);
			p_c[l]  = (PW'(phi_s3[l]) << PP_LO_W) + PW'(plo_s3[l]) + RND_H;
			hm_c[l] = p_c[l][K_SHIFT +: AW];
		end
	end

	// s5 inputs
	assign hx_e = CW'(h_s4[0]);
	assign hy_e = CW'(h_s4[1]);

	// s6: round each doubled cube axis and measure its error
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ca_c[j] = c_s5[j][CW-1] ? CW'(-c_s5[j]) : CW'(c_s5[j]);
			cs_c[j] = ca_c[j] + HALF_C;
			im_c[j] = cs_c[j][CW-1:FRAC_BITS+1];
			dd_c[j] = ONE_C - {1'b0, ca_c[j][FRAC_BITS:0]};
		end
	end

	// s7: rebuild the axis with the largest error
	assign q_big = (d_s6[0] > d_s6[1]) && (d_s6[0] > d_s6[2]);
	assign r_big = !q_big && (d_s6[1] > d_s6[2]);

	// s8: doubled column
	assign col_c = YW'(qf_s7) + YW'(qf_s7) + YW'(rf_s7);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_d;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		mx_s1 <= mx_c[M_W-1:0];
		my_s1 <= my_c[M_W-1:0];

		neg_s2[0] <= mx_s1[M_W-1];
		neg_s2[1] <= my_s1[M_W-1];
		num_s2[0] <= NW'({ax_c[MAG_W-1:0], {(FRAC_BITS+1){1'b0}}})
			+ NW'(zeff[ZOOM_W-1:1]);
		num_s2[1] <= NW'({ay_c[MAG_W-1:0], {(FRAC_BITS+1){1'b0}}})
			+ NW'(zeff[ZOOM_W-1:1]);

		plo_s3[0]  <= PLW'(wa_c[0][PP_LO_W-1:0]) * PLW'(K_HX_MAG);
		phi_s3[0]  <= PHW'(wa_c[0][AW-1:PP_LO_W]) * PHW'(K_HX_MAG);
		hneg_s3[0] <= w_d[0][WW-1];
		plo_s3[1]  <= PLW'(wa_c[1][PP_LO_W-1:0]) * PLW'(K_HY_MAG);
		phi_s3[1]  <= PHW'(wa_c[1][AW-1:PP_LO_W]) * PHW'(K_HY_MAG);
		hneg_s3[1] <= !w_d[1][WW-1];

		for (int l = 0; l < 2; l++) begin
			h_s4[l] <= hneg_s3[l] ? -signed'({1'b0, hm_c[l]}) : signed'({1'b0, hm_c[l]});
		end

		c_s5[0] <= hx_e - hy_e;
		c_s5[1] <= hy_e + hy_e;
		c_s5[2] <= -hx_e - hy_e;

		for (int j = 0; j < 3; j++) begin
			i_s6[j] <= c_s5[j][CW-1] ? -signed'({1'b0, im_c[j]}) : signed'({1'b0, im_c[j]});
			d_s6[j] <= ca_c[j][FRAC_BITS] ? dd_c[j][FRAC_BITS:0] : ca_c[j][FRAC_BITS:0];
		end

		qf_s7 <= q_big ? (-XW'(i_s6[1]) - XW'(i_s6[2])) : XW'(i_s6[0]);
		rf_s7 <= r_big ? (-XW'(i_s6[0]) - XW'(i_s6[2])) : XW'(i_s6[1]);

		col_s8 <= sat_out(col_c);
		row_s8 <= sat_out(YW'(rf_s7));
	end

	assign done        = vld_s8;
	assign cell_column = col_s8;
	assign cell_row    = row_s8;

endmodule

### sim/screen_point_to_hex_cell_tb.sv
// screen_point_to_hex_cell_tb: self-checking testbench for the screen point to hex cell mapper
// depends on sphc_pkg and screen_point_to_hex_cell; predicts every cell in fixed point
module screen_point_to_hex_cell_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sphc_pkg::*;

	localparam int     FRAC         = 16;
	localparam int     CLK_PERIOD   = 12;
	localparam int     RESET_CYCLES = 11;
	localparam int     DRAIN_CYCLES = FRAC + 28 + 16;
	localparam int     LIMIT_CYCLES = 200000;
	localparam int     PHASES       = 16;
	localparam int     PHASE_POINTS = 53;

	// fixed-point constants of the hex transform
	localparam longint HEX_X_Q20        = 1210791;
	localparam longint HEX_Y_Q20        = -699051;
	localparam int     Q20_SHIFT        = 20;
	localparam int     WORLD_CLAMP_BITS = 17;

	// first register index that maps to nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;

	typedef enum logic {OP_POINT, OP_WRITE} op_kind_t;

	typedef struct {
		op_kind_t               kind;
		logic [SCR_W-1:0]       sx;
		logic [SCR_W-1:0]       sy;
		int unsigned            gap_pct;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
	} pending_op_t;

	typedef struct {
		logic signed [OUT_W-1:0] column;
		logic signed [OUT_W-1:0] row;
	} cell_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [SCR_W-1:0]         screen_x = '0;
	logic [SCR_W-1:0]         screen_y = '0;
	logic                     done;
	logic signed [OUT_W-1:0]  cell_column;
	logic signed [OUT_W-1:0]  cell_row;
	logic                     wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]     wr_index = '0;
	logic [CFG_DATA_W-1:0]    wr_data = '0;

	// shadow copy of the view registers
	logic [VP_W-1:0]          cfg_width = VW_RST;
	logic [VP_W-1:0]          cfg_height = VH_RST;
	logic signed [PAN_W-1:0]  cfg_pan_x = '0;
	logic signed [PAN_W-1:0]  cfg_pan_y = '0;
	logic [ZOOM_W-1:0]        cfg_zoom = ZOOM_RST;

	pending_op_t  pending_ops[$];
	cell_t        expected_cells[$];
	logic         item_taken = 1'b0;
	int           fail_count = 0;

	screen_point_to_hex_cell #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.screen_x(screen_x),
		.screen_y(screen_y),
		.done(done),
		.cell_column(cell_column),
		.cell_row(cell_row),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// n/d rounded to nearest, ties away from zero, d > 0
	function automatic longint div_nearest(input longint n, input longint d);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic signed [OUT_W-1:0] clip16(input longint v);
		longint c;
		c = v;
		if (c > 32767)
			c = 32767;
		else if (c < -32768)
			c = -32768;
		return c[OUT_W-1:0];
	endfunction

	// screen pixel -> world -> hex axes -> cube rounding, with the current view
	function automatic cell_t predict_cell(input logic [SCR_W-1:0] sx, input logic [SCR_W-1:0] sy);
		longint z, lim, one, mx, my, wx, wy, hx, hy;
		longint r2, q2, s2, qi, ri, si, dq, dr, ds;
		cell_t  c;
		z   = (cfg_zoom == 0) ? 1 : longint'(cfg_zoom);
		lim = longint'(1) << (WORLD_CLAMP_BITS + FRAC);
		one = longint'(1) << (FRAC + 1);

		// point moved to the view center, y pointing up, in 1/256 pixel
		mx = longint'(sx) * 256 - longint'(cfg_width) * 128 + longint'(cfg_pan_x);
		my = longint'(cfg_height) * 128 - longint'(sy) * 256 - longint'(cfg_pan_y);

		wx = clamp_sym(div_nearest(mx * (longint'(2) << FRAC), z), lim);
		wy = clamp_sym(div_nearest(my * (longint'(2) << FRAC), z), lim);

		hx = div_nearest(wx * HEX_X_Q20, longint'(1) << Q20_SHIFT);
		hy = div_nearest(wy * HEX_Y_Q20, longint'(1) << Q20_SHIFT);

		// doubled cube axes, rebuild the one with the largest rounding error
		r2 = 2 * hy;
		q2 = hx - hy;
		s2 = -q2 - r2;
		qi = div_nearest(q2, one);
		ri = div_nearest(r2, one);
		si = div_nearest(s2, one);
		dq = magnitude(qi * one - q2);
		dr = magnitude(ri * one - r2);
		ds = magnitude(si * one - s2);
		if (dq > dr && dq > ds)
			qi = -ri - si;
		else if (dr > ds)
			ri = -qi - si;

		c.column = clip16(2 * qi + ri);
		c.row    = clip16(ri);
		return c;
	endfunction

	// value in the low bits, random junk above
	function automatic logic [CFG_DATA_W-1:0] with_junk(input int keep, input logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] r;
		r = CFG_DATA_W'($urandom);
		for (int i = 0; i < keep; i++)
			r[i] = value[i];
		return r;
	endfunction

	task automatic queue_point(input int x, input int y, input int unsigned gap);
		pending_op_t op;
		op.kind    = OP_POINT;
		op.sx      = x[SCR_W-1:0];
		op.sy      = y[SCR_W-1:0];
		op.gap_pct = gap;
		op.idx     = '0;
		op.data    = '0;
		pending_ops.push_back(op);
	endtask

	task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		pending_op_t op;
		op.kind    = OP_WRITE;
		op.sx      = '0;
		op.sy      = '0;
		op.gap_pct = 0;
		op.idx     = idx;
		op.data    = data;
		pending_ops.push_back(op);
	endtask

	function automatic logic [VP_W-1:0] pick_viewport();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return VP_W'($urandom_range(1, 4096));
	endfunction

	function automatic logic [PAN_W-1:0] pick_pan();
		int          r;
		logic [PAN_W-1:0] p;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 24'h800000;
		if (r == 1)
			return 24'h7FFFFF;
		if (r < 10) begin
			p = PAN_W'($urandom_range(0, 65535));
			return $urandom_range(0, 1) ? -p : p;
		end
		return PAN_W'($urandom);
	endfunction

	function automatic logic [ZOOM_W-1:0] pick_zoom();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return 20'd1;
		if (r == 2)
			return '1;
		if (r < 8)
			return ZOOM_W'($urandom_range(1, 1023));
		if (r < 16)
			return ZOOM_W'($urandom_range(1024, 65535));
		return ZOOM_W'($urandom_range(65536, 1048575));
	endfunction

	function automatic int pick_coord();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return 4095;
		return $urandom_range(0, 4095);
	endfunction

	// driver: items and register writes, changed on the falling edge
	always @(negedge clk) begin
		logic        next_start;
		logic        next_wr;
		pending_op_t op;
		next_start = start;
		next_wr    = 1'b0;
		if (arst_n && (!start || item_taken)) begin
			next_start = 1'b0;
			if (pending_ops.size() > 0) begin
				if (pending_ops[0].kind == OP_POINT) begin
					if ($urandom_range(0, 99) >= pending_ops[0].gap_pct) begin
						op = pending_ops.pop_front();
						screen_x <= op.sx;
						screen_y <= op.sy;
						next_start = 1'b1;
					end
				end else if (expected_cells.size() == 0) begin
					// registers change only with nothing in flight
					op = pending_ops.pop_front();
					wr_index <= op.idx;
					wr_data <= op.data;
					next_wr = 1'b1;
				end
			end
		end
		start <= next_start;
		wr_en <= next_wr;
	end

	// monitor: track writes, predict accepted items, check results
	always @(posedge clk or negedge arst_n) begin
		cell_t want;
		if (!arst_n) begin
			cfg_width  <= VW_RST;
			cfg_height <= VH_RST;
			cfg_pan_x  <= '0;
			cfg_pan_y  <= '0;
			cfg_zoom   <= ZOOM_RST;
			item_taken <= 1'b0;
		end else begin
			if (done) begin
				if (expected_cells.size() == 0) begin
					$error("result with no item outstanding: column %0d row %0d",
						cell_column, cell_row);
					fail_count++;
				end else begin
					want = expected_cells.pop_front();
					if (cell_column !== want.column) begin
						$error("cell_column: expected %0d, actual %0d", want.column, cell_column);
						fail_count++;
					end
					if (cell_row !== want.row) begin
						$error("cell_row: expected %0d, actual %0d", want.row, cell_row);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_cells.push_back(predict_cell(screen_x, screen_y));
			item_taken <= start && !busy;
			if (wr_en) begin
				case (wr_index)
					CFG_VIEWPORT_WIDTH:  cfg_width <= wr_data[VP_W-1:0];
					CFG_VIEWPORT_HEIGHT: cfg_height <= wr_data[VP_W-1:0];
					CFG_PAN_X:           cfg_pan_x <= wr_data[PAN_W-1:0];
					CFG_PAN_Y:           cfg_pan_y <= wr_data[PAN_W-1:0];
					CFG_ZOOM:            cfg_zoom <= wr_data[ZOOM_W-1:0];
					default:             ;
				endcase
			end
		end
	end

	// watchdog
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned gap_modes[4];
		int unsigned gap;
		gap_modes = '{0, 51, 0, 6};

		// reset view: corners and the center
		queue_point(0, 0, 0);
		queue_point(4095, 4095, 0);
		queue_point(0, 4095, 0);
		queue_point(4095, 0, 0);
		queue_point(512, 384, 0);
		queue_point(513, 384, 0);

		// zoom of one: far points hit the world clamp and saturate
		queue_write(CFG_ZOOM, with_junk(ZOOM_W, 20'd1));
		queue_point(0, 0, 0);
		queue_point(4095, 4095, 0);
		queue_point(512, 384, 0);

		// zoom of zero behaves as one
		queue_write(CFG_ZOOM, with_junk(ZOOM_W, 20'd0));
		queue_point(100, 700, 0);
		queue_point(4095, 0, 0);

		// pan extremes at the largest zoom
		queue_write(CFG_ZOOM, with_junk(ZOOM_W, 20'hFFFFF));
		queue_write(CFG_PAN_X, 24'h800000);
		queue_write(CFG_PAN_Y, 24'h7FFFFF);
		queue_point(0, 0, 0);
		queue_point(4095, 4095, 0);
		queue_write(CFG_PAN_X, 24'h7FFFFF);
		queue_write(CFG_PAN_Y, 24'h800000);
		queue_point(0, 0, 0);
		queue_point(4095, 4095, 0);

		// zero viewport puts the center at the origin, then the widest one
		queue_write(CFG_VIEWPORT_WIDTH, with_junk(VP_W, 13'd0));
		queue_write(CFG_VIEWPORT_HEIGHT, with_junk(VP_W, 13'd0));
		queue_write(CFG_PAN_X, 24'd0);
		queue_write(CFG_PAN_Y, 24'd0);
		queue_write(CFG_ZOOM, with_junk(ZOOM_W, 20'd256));
		queue_point(0, 0, 0);
		queue_point(4095, 4095, 0);
		queue_write(CFG_VIEWPORT_WIDTH, with_junk(VP_W, 13'h1FFF));
		queue_write(CFG_VIEWPORT_HEIGHT, with_junk(VP_W, 13'd4096));
		queue_point(0, 0, 0);
		queue_point(4095, 4095, 0);

		// writes to unmapped indexes leave the view alone
		for (int k = 0; k < 3; k++)
			queue_write(CFG_UNMAPPED_LO + CFG_IDX_W'(k), CFG_DATA_W'($urandom));
		queue_point(2000, 1000, 0);
		queue_point(17, 3000, 0);

		// random views, each followed by a burst of random points
		for (int ph = 0; ph < PHASES; ph++) begin
			gap = gap_modes[ph % 4];
			queue_write(CFG_VIEWPORT_WIDTH, with_junk(VP_W, pick_viewport()));
			queue_write(CFG_VIEWPORT_HEIGHT, with_junk(VP_W, pick_viewport()));
			queue_write(CFG_PAN_X, pick_pan());
			queue_write(CFG_PAN_Y, pick_pan());
			queue_write(CFG_ZOOM, with_junk(ZOOM_W, pick_zoom()));
			if ($urandom_range(0, 3) == 0)
				queue_write(CFG_UNMAPPED_LO + CFG_IDX_W'($urandom_range(0, 2)),
					CFG_DATA_W'($urandom));
			for (int i = 0; i < PHASE_POINTS; i++)
				queue_point(pick_coord(), pick_coord(), gap);
		end

		// single reset at the start of the run
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || start)
			@(posedge clk);
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
hdl/sphc_pkg.sv
hdl/sphc_div.sv
hdl/screen_point_to_hex_cell.sv
sim/screen_point_to_hex_cell_tb.sv
